>>> hdl/lirfp_pkg.sv
package lirfp_pkg;

	// framing bytes
	localparam logic [7:0] BYTE_PIPE    = 8'd124;
	localparam logic [7:0] BYTE_NL      = 8'd10;
	localparam logic [7:0] BYTE_PLUS    = 8'd43;
	localparam logic [7:0] BYTE_MINUS   = 8'd45;
	localparam logic [7:0] BYTE_POINT   = 8'd46;
	localparam logic [7:0] BYTE_ZERO    = 8'd48;
	localparam logic [7:0] BYTE_NINE    = 8'd57;
	localparam logic [7:0] CHAR_N       = 8'd78;
	localparam logic [7:0] CHAR_R       = 8'd82;
	localparam logic [7:0] CHAR_O       = 8'd79;

	localparam logic [4:0] POS_MAX      = 5'd31;
	localparam logic [4:0] COL_MAX      = 5'd31;
	localparam logic [4:0] DATE_LEN     = 5'd10;

	// match strings, right-justified in a fixed word
	localparam int TEXT_W = 136;
	localparam int N_INSTR = 4;
	localparam int N_MODE = 3;

	localparam logic [TEXT_W-1:0] INSTR_TXT [N_INSTR] = '{
		"DELIVER IN PERSON", "TAKE BACK RETURN", "COLLECT COD", "NONE"
	};
	localparam logic [4:0] INSTR_LEN [N_INSTR] = '{5'd17, 5'd16, 5'd11, 5'd4};
	localparam logic [TEXT_W-1:0] MODE_TXT [N_MODE] = '{"MAIL", "AIR", "AIR REG"};
	localparam logic [4:0] MODE_LEN [N_MODE] = '{5'd4, 5'd3, 5'd7};

	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_INT   = 3'd1,
		KIND_DEC   = 3'd2,
		KIND_RFLAG = 3'd3,
		KIND_SFLAG = 3'd4,
		KIND_DATE  = 3'd5,
		KIND_INSTR = 3'd6,
		KIND_MODE  = 3'd7
	} kind_t;

	typedef struct packed {
		logic [4:0]  char_pos;
		logic [31:0] acc;
		logic        neg;
		logic        stopped;
		logic        started;
		logic        point;
		logic [1:0]  frac;
		logic [7:0]  first_char;
		logic [3:0]  instr_flags;
		logic [2:0]  mode_flags;
	} field_state_t;

	localparam field_state_t FIELD_CLEAR = '{
		char_pos:    5'd0,
		acc:         32'd0,
		neg:         1'b0,
		stopped:     1'b0,
		started:     1'b0,
		point:       1'b0,
		frac:        2'd0,
		first_char:  8'd0,
		instr_flags: 4'hF,
		mode_flags:  3'h7
	};

	function automatic kind_t col_kind(input logic [4:0] col);
		kind_t k;
		case (col)
			5'd0, 5'd1, 5'd2, 5'd4: k = KIND_INT;
			5'd5, 5'd6, 5'd7:       k = KIND_DEC;
			5'd8:                   k = KIND_RFLAG;
			5'd9:                   k = KIND_SFLAG;
			5'd10, 5'd11, 5'd12:    k = KIND_DATE;
			5'd13:                  k = KIND_INSTR;
			5'd14:                  k = KIND_MODE;
			default:                k = KIND_NONE;
		endcase
		return k;
	endfunction

	// byte b matches position p of a right-justified string of length len
	function automatic logic text_hit(input logic [TEXT_W-1:0] txt, input logic [4:0] len,
			input logic [4:0] p, input logic [7:0] b);
		logic [4:0] idx;
		logic       hit;
		idx = len - p - 5'd1;
		if (p >= len) begin
			hit = 1'b0;
		end else begin
			hit = (txt[{idx, 3'b000} +: 8] == b);
		end
		return hit;
	endfunction

	// decimal weight of each date position, separators weigh nothing
	function automatic logic [23:0] date_weight(input logic [4:0] p);
		logic [23:0] w;
		case (p)
			5'd0:    w = 24'd10000000;
			5'd1:    w = 24'd1000000;
			5'd2:    w = 24'd100000;
			5'd3:    w = 24'd10000;
			5'd5:    w = 24'd1000;
			5'd6:    w = 24'd100;
			5'd8:    w = 24'd10;
			5'd9:    w = 24'd1;
			default: w = 24'd0;
		endcase
		return w;
	endfunction

	// ascii zero times the weights of the first n positions
	function automatic logic [29:0] date_bias(input logic [3:0] n);
		logic [29:0] v;
		case (n)
			4'd0:    v = 30'd0;
			4'd1:    v = 30'd480000000;
			4'd2:    v = 30'd528000000;
			4'd3:    v = 30'd532800000;
			4'd4:    v = 30'd533280000;
			4'd5:    v = 30'd533280000;
			4'd6:    v = 30'd533328000;
			4'd7:    v = 30'd533332800;
			4'd8:    v = 30'd533332800;
			4'd9:    v = 30'd533333280;
			default: v = 30'd533333328;
		endcase
		return v;
	endfunction

endpackage

>>> hdl/lirfp_decode.sv
module lirfp_decode (
	input  lirfp_pkg::kind_t        kind,
	input  lirfp_pkg::field_state_t field,
	output logic signed [31:0]      value
);

	localparam logic signed [33:0] POS_LIM = 34'sd2147483647;
	localparam logic signed [33:0] NEG_LIM = -34'sd2147483648;
	localparam logic [38:0] SAT_MAG = 39'h0080000000;

	logic [38:0]        x10;
	logic [38:0]        x100;
	logic [38:0]        scaled;
	logic [31:0]        mag;
	logic [31:0]        num_val;
	logic [3:0]         date_n;
	logic signed [33:0] diff;
	logic [31:0]        date_val;
	logic [31:0]        instr_val;
	logic [31:0]        mode_val;
	logic [31:0]        result;

	// missing fraction digits scale up by ten each
	always_comb begin
		x10  = {4'b0, field.acc, 3'b0} + {6'b0, field.acc, 1'b0};
		x100 = {1'b0, field.acc, 6'b0} + {2'b0, field.acc, 5'b0} + {5'b0, field.acc, 2'b0};
		if (kind == lirfp_pkg::KIND_DEC) begin
			case (field.frac)
				2'd2:    scaled = {7'b0, field.acc};
				2'd1:    scaled = x10;
				default: scaled = x100;
			endcase
		end else begin
			scaled = {7'b0, field.acc};
		end
		mag = (scaled > SAT_MAG) ? SAT_MAG[31:0] : scaled[31:0];
		if (field.neg) begin
			num_val = ~mag + 32'd1;
		end else begin
			num_val = mag[31] ? 32'h7FFF_FFFF : mag;
		end
	end

	always_comb begin
		date_n = (field.char_pos < lirfp_pkg::DATE_LEN) ? field.char_pos[3:0]
			: lirfp_pkg::DATE_LEN[3:0];
		diff = $signed({2'b00, field.acc}) - $signed({4'b0000, lirfp_pkg::date_bias(date_n)});
		if (diff > POS_LIM) begin
			date_val = 32'h7FFF_FFFF;
		end else if (diff < NEG_LIM) begin
			date_val = 32'h8000_0000;
		end else begin
			date_val = diff[31:0];
		end
	end

	// lowest matching entry wins
	always_comb begin
		instr_val = 32'd0;
		for (int i = lirfp_pkg::N_INSTR - 1; i >= 0; i--) begin
			if (field.instr_flags[i] && field.char_pos == lirfp_pkg::INSTR_LEN[i]) begin
				instr_val = 32'(i + 1);
			end
		end
		mode_val = 32'd0;
		for (int i = lirfp_pkg::N_MODE - 1; i >= 0; i--) begin
			if (field.mode_flags[i] && field.char_pos == lirfp_pkg::MODE_LEN[i]) begin
				mode_val = 32'(i + 1);
			end
		end
	end

	always_comb begin
		case (kind)
			lirfp_pkg::KIND_INT, lirfp_pkg::KIND_DEC: result = num_val;
			lirfp_pkg::KIND_RFLAG: begin
				if (field.first_char == lirfp_pkg::CHAR_N) begin
					result = 32'd0;
				end else if (field.first_char == lirfp_pkg::CHAR_R) begin
					result = 32'd1;
				end else begin
					result = 32'd2;
				end
			end
			lirfp_pkg::KIND_SFLAG: result = (field.first_char == lirfp_pkg::CHAR_O) ? 32'd0 : 32'd1;
			lirfp_pkg::KIND_DATE:  result = date_val;
			lirfp_pkg::KIND_INSTR: result = instr_val;
			lirfp_pkg::KIND_MODE:  result = mode_val;
			default:               result = 32'd0;
		endcase
	end

	assign value = $signed(result);

endmodule

>>> hdl/lineitem_record_field_parser_core.sv
// a byte is held in the input register, then its result is written to the result register
// throughput: one byte per cycle, set by the field update between input and result register
// the input stage stalls only while a result waits in the output register and is not taken
// reset: arst_n clears column, line counter, field state and both valid flags at once
module lineitem_record_field_parser_core #(
	parameter logic [32:0] MAX_RECORDS = 33'd65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         column,
	output logic signed [31:0] value,
	output logic               field_kept,
	output logic [15:0]        record_index,
	output logic               record_end
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	lirfp_pkg::field_state_t field_q;
	lirfp_pkg::field_state_t field_d;
	lirfp_pkg::field_state_t num_d;
	logic [4:0]  col_q;
	logic [4:0]  col_d;
	logic [15:0] line_q;
	logic [15:0] line_d;

	// result register
	logic               out_valid_q;
	logic [4:0]         column_q;
	logic signed [31:0] value_q;
	logic               kept_q;
	logic [15:0]        record_q;
	logic               end_q;

	logic               advance;
	logic               step;
	logic               emit;
	logic               is_end;
	lirfp_pkg::kind_t   kind;
	logic signed [31:0] dec_value;
	logic [16:0]        line_inc;
	logic [15:0]        line_next;
	logic               digit;
	logic               blank;
	logic               sign;
	logic               dot;
	logic               is_dec;
	logic               go;
	logic [35:0]        push_sum;
	logic [31:0]        pushed;
	logic [31:0]        date_prod;

	// output side frees up when empty or being taken
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	assign kind = lirfp_pkg::col_kind(col_q);

	// line counter wraps at the configured record count
	assign line_inc  = {1'b0, line_q} + 17'd1;
	assign line_next = ({16'b0, line_inc} >= MAX_RECORDS) ? 16'd0 : line_inc[15:0];

	// number field: leading blanks, sign, digits, one optional point for decimals
	always_comb begin
		digit  = (byte_s1 >= lirfp_pkg::BYTE_ZERO) && (byte_s1 <= lirfp_pkg::BYTE_NINE);
		blank  = byte_s1 inside {8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
		sign   = (byte_s1 == lirfp_pkg::BYTE_PLUS) || (byte_s1 == lirfp_pkg::BYTE_MINUS);
		dot    = (byte_s1 == lirfp_pkg::BYTE_POINT);
		is_dec = (kind == lirfp_pkg::KIND_DEC);

		// times ten plus digit, saturating at the magnitude of the most negative value
		push_sum = {1'b0, field_q.acc, 3'b0} + {3'b0, field_q.acc, 1'b0}
			+ {28'b0, byte_s1 - lirfp_pkg::BYTE_ZERO};
		pushed = (push_sum > 36'h0_8000_0000) ? 32'h8000_0000 : push_sum[31:0];

		num_d = field_q;
		go    = 1'b0;
		if (!field_q.stopped) begin
			if (field_q.started) begin
				go = 1'b1;
			end else if (blank) begin
				go = 1'b0;
			end else if (sign) begin
				num_d.neg     = (byte_s1 == lirfp_pkg::BYTE_MINUS);
				num_d.started = 1'b1;
			end else if (!digit && !(is_dec && dot)) begin
				num_d.stopped = 1'b1;
			end else begin
				num_d.started = 1'b1;
				go            = 1'b1;
			end
		end
		if (go) begin
			if (digit) begin
				if (!is_dec || !field_q.point) begin
					num_d.acc = pushed;
				end else if (field_q.frac != 2'd2) begin
					// only two fraction digits count, the rest are dropped
					num_d.acc  = pushed;
					num_d.frac = field_q.frac + 2'd1;
				end
			end else if (is_dec && dot && !field_q.point) begin
				num_d.point = 1'b1;
			end else begin
				num_d.stopped = 1'b1;
			end
		end
	end

	assign date_prod = 32'(byte_s1) * 32'(lirfp_pkg::date_weight(field_q.char_pos));

	always_comb begin
		field_d = field_q;
		col_d   = col_q;
		line_d  = line_q;
		emit    = 1'b0;
		is_end  = 1'b0;
		if (byte_s1 == lirfp_pkg::BYTE_PIPE) begin
			// only decoded columns produce a result at a separator
			emit    = (kind != lirfp_pkg::KIND_NONE);
			col_d   = (col_q != lirfp_pkg::COL_MAX) ? col_q + 5'd1 : col_q;
			field_d = lirfp_pkg::FIELD_CLEAR;
		end else if (byte_s1 == lirfp_pkg::BYTE_NL) begin
			// end of record always gives a result
			emit    = 1'b1;
			is_end  = 1'b1;
			col_d   = 5'd0;
			line_d  = line_next;
			field_d = lirfp_pkg::FIELD_CLEAR;
		end else begin
			if (kind == lirfp_pkg::KIND_INT || kind == lirfp_pkg::KIND_DEC) begin
				field_d = num_d;
			end else if (kind == lirfp_pkg::KIND_DATE && field_q.char_pos < lirfp_pkg::DATE_LEN) begin
				field_d.acc = field_q.acc + date_prod;
			end
			if (field_q.char_pos == 5'd0) begin
				field_d.first_char = byte_s1;
			end
			// string matchers drop out at the first mismatch
			for (int i = 0; i < lirfp_pkg::N_INSTR; i++) begin
				if (!lirfp_pkg::text_hit(lirfp_pkg::INSTR_TXT[i], lirfp_pkg::INSTR_LEN[i],
						field_q.char_pos, byte_s1)) begin
					field_d.instr_flags[i] = 1'b0;
				end
			end
			for (int i = 0; i < lirfp_pkg::N_MODE; i++) begin
				if (!lirfp_pkg::text_hit(lirfp_pkg::MODE_TXT[i], lirfp_pkg::MODE_LEN[i],
						field_q.char_pos, byte_s1)) begin
					field_d.mode_flags[i] = 1'b0;
				end
			end
			field_d.char_pos = (field_q.char_pos != lirfp_pkg::POS_MAX)
				? field_q.char_pos + 5'd1 : field_q.char_pos;
		end
	end

	// value of the field being closed, from the state before this byte
	lirfp_decode u_decode (
		.kind  (kind),
		.field (field_q),
		.value (dec_value)
	);

	// input register, one byte deep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// parser state moves on with each byte that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= lirfp_pkg::FIELD_CLEAR;
			col_q   <= 5'd0;
			line_q  <= 16'd0;
		end else if (step) begin
			field_q <= field_d;
			col_q   <= col_d;
			line_q  <= line_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			column_q <= col_q;
			value_q  <= dec_value;
			kept_q   <= (kind != lirfp_pkg::KIND_NONE);
			record_q <= line_q;
			end_q    <= is_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign column       = column_q;
	assign value        = value_q;
	assign field_kept   = kept_q;
	assign record_index = record_q;
	assign record_end   = end_q;

	// columns that are not decoded carry a zero value
	a_unkept_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !field_kept |-> value == 32'sd0)
		else $error("unkept column with nonzero value");

	// the input side only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a waiting result");

	// a separator or newline leaves a clean field
	a_field_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && (byte_s1 == lirfp_pkg::BYTE_PIPE || byte_s1 == lirfp_pkg::BYTE_NL)
		|=> field_q.char_pos == 5'd0 && field_q.acc == 32'd0 && field_q.instr_flags == 4'hF)
		else $error("field state not cleared at terminator");

	// newline always produces an end-of-record result and restarts the columns
	a_newline: assert property (@(posedge clk) disable iff (!arst_n)
		step && byte_s1 == lirfp_pkg::BYTE_NL |=> col_q == 5'd0 && out_valid_q && end_q)
		else $error("newline without end-of-record result");

	// only the decoded columns are flagged as kept
	a_kept_column: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kept |-> column != 5'd3 && column < 5'd15)
		else $error("kept flag on an undecoded column");

endmodule

>>> dv/lineitem_record_field_parser_core_tb.sv
module lineitem_record_field_parser_core_tb;

	// run length and the guard against a hung run
	localparam int          RANDOM_ITEMS = 600;
	localparam int          CALM_TAIL    = 100;
	localparam int          DIR_ROWS     = 31;
	localparam int unsigned RECORD_LIMIT = 65536;
	localparam int          TIME_LIMIT   = 2000000;

	// one result as the block shows it
	typedef struct packed {
		logic [4:0]  column;
		logic [31:0] value;
		logic        kept;
		logic [15:0] rec_index;
		logic        rec_end;
	} parse_result_t;

	// one row of the directed table: byte, and a typed-in result where there is one
	typedef struct packed {
		logic [7:0]    data;
		logic          typed;
		parse_result_t want;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_ready;
	logic [4:0]         column;
	logic signed [31:0] value;
	logic               field_kept;
	logic [15:0]        record_index;
	logic               record_end;

	lineitem_record_field_parser_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column       (column),
		.value        (value),
		.field_kept   (field_kept),
		.record_index (record_index),
		.record_end   (record_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results still owed by the block, oldest first
	parse_result_t pending_fields [$];
	parse_result_t oldest;
	int            fail_count = 0;
	bit            idle_on = 1'b1;
	int            stall_left = 0;
	logic [7:0]    random_text [$];

	// match words for the instruction and mode columns
	string instr_words [4] = '{"DELIVER IN PERSON", "TAKE BACK RETURN", "COLLECT COD", "NONE"};
	string mode_words [3]  = '{"MAIL", "AIR", "AIR REG"};

	// weight of each date position, separators weigh nothing
	localparam int unsigned DATE_WT [10] = '{
		10000000, 1000000, 100000, 10000, 0, 1000, 100, 0, 10, 1
	};

	// directed table: framing after reset, empty fields, signs, flags, match words
	dir_row_t directed_table [DIR_ROWS] = '{
		'{lirfp_pkg::BYTE_NL,    1'b1, '{5'd0,  32'd0,    1'b1, 16'd0, 1'b1}},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd0,  32'd0,    1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd1,  32'd0,    1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::BYTE_PLUS,  1'b0, '0},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd2,  32'd0,    1'b1, 16'd1, 1'b0}},
		'{8'd0,                  1'b0, '0},
		'{8'd255,                1'b0, '0},
		'{lirfp_pkg::BYTE_PIPE,  1'b0, '0},
		'{lirfp_pkg::BYTE_MINUS, 1'b0, '0},
		'{"7",                   1'b0, '0},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd4,  -32'sd7,  1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd5,  32'd0,    1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::BYTE_POINT, 1'b0, '0},
		'{"5",                   1'b0, '0},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd6,  32'd50,   1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd7,  32'd0,    1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::CHAR_R,     1'b0, '0},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd8,  32'd1,    1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd9,  32'd1,    1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd10, 32'd0,    1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd11, 32'd0,    1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd12, 32'd0,    1'b1, 16'd1, 1'b0}},
		'{lirfp_pkg::CHAR_N,     1'b0, '0},
		'{lirfp_pkg::CHAR_O,     1'b0, '0},
		'{lirfp_pkg::CHAR_N,     1'b0, '0},
		'{"E",                   1'b0, '0},
		'{lirfp_pkg::BYTE_PIPE,  1'b1, '{5'd13, 32'd4,    1'b1, 16'd1, 1'b0}},
		'{"A",                   1'b0, '0},
		'{"I",                   1'b0, '0},
		'{lirfp_pkg::CHAR_R,     1'b0, '0},
		'{lirfp_pkg::BYTE_NL,    1'b1, '{5'd14, 32'd2,    1'b1, 16'd1, 1'b1}}
	};

	// ---------------------------------------------------------------
	// field decoder, own copy of column, field and line state
	// ---------------------------------------------------------------
	logic [4:0]  col_no;
	logic [4:0]  char_no;
	logic [31:0] acc;
	logic        num_neg, num_stopped, num_started, num_point;
	logic [1:0]  frac_no;
	logic [7:0]  lead_char;
	logic [3:0]  instr_hits;
	logic [2:0]  mode_hits;
	logic [15:0] line_no;

	function automatic lirfp_pkg::kind_t column_kind(input logic [4:0] c);
		case (c)
			5'd0, 5'd1, 5'd2, 5'd4: return lirfp_pkg::KIND_INT;
			5'd5, 5'd6, 5'd7:       return lirfp_pkg::KIND_DEC;
			5'd8:                   return lirfp_pkg::KIND_RFLAG;
			5'd9:                   return lirfp_pkg::KIND_SFLAG;
			5'd10, 5'd11, 5'd12:    return lirfp_pkg::KIND_DATE;
			5'd13:                  return lirfp_pkg::KIND_INSTR;
			5'd14:                  return lirfp_pkg::KIND_MODE;
			default:                return lirfp_pkg::KIND_NONE;
		endcase
	endfunction

	task automatic clear_field_state();
		char_no     = '0;
		acc         = '0;
		num_neg     = 1'b0;
		num_stopped = 1'b0;
		num_started = 1'b0;
		num_point   = 1'b0;
		frac_no     = '0;
		lead_char   = '0;
		instr_hits  = 4'hF;
		mode_hits   = 3'h7;
	endtask

	// times ten plus digit, held at the magnitude of the most negative value
	function automatic logic [31:0] shift_in_digit(input logic [31:0] a, input logic [7:0] b);
		longint unsigned v;
		v = 64'(a) * 64'd10 + 64'(b - lirfp_pkg::BYTE_ZERO);
		return (v > 64'h8000_0000) ? 32'h8000_0000 : v[31:0];
	endfunction

	function automatic logic [31:0] clamp_signed(input longint m);
		if (m > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (m < -64'sd2147483648)
			return 32'h8000_0000;
		return m[31:0];
	endfunction

	task automatic number_step(input logic [7:0] b, input bit dec);
		bit digit;
		digit = (b >= lirfp_pkg::BYTE_ZERO) && (b <= lirfp_pkg::BYTE_NINE);
		if (num_stopped)
			return;
		if (!num_started) begin
			// leading blanks: tab, vertical tab, form feed, carriage return, space
			if (b == 8'd9 || b == 8'd11 || b == 8'd12 || b == 8'd13 || b == 8'd32)
				return;
			if (b == lirfp_pkg::BYTE_PLUS || b == lirfp_pkg::BYTE_MINUS) begin
				num_neg     = (b == lirfp_pkg::BYTE_MINUS);
				num_started = 1'b1;
				return;
			end
			if (!digit && !(dec && b == lirfp_pkg::BYTE_POINT)) begin
				num_stopped = 1'b1;
				return;
			end
			num_started = 1'b1;
		end
		if (digit) begin
			if (!dec || !num_point) begin
				acc = shift_in_digit(acc, b);
			end else if (frac_no < 2'd2) begin
				acc     = shift_in_digit(acc, b);
				frac_no = frac_no + 2'd1;
			end
			return;
		end
		if (dec && b == lirfp_pkg::BYTE_POINT && !num_point) begin
			num_point = 1'b1;
			return;
		end
		num_stopped = 1'b1;
	endtask

	function automatic logic [31:0] field_value(input lirfp_pkg::kind_t k);
		longint mag;
		longint bias;
		int     n;
		case (k)
			lirfp_pkg::KIND_INT, lirfp_pkg::KIND_DEC: begin
				mag = longint'(acc);
				// scale a decimal up to hundredths for missing fraction digits
				if (k == lirfp_pkg::KIND_DEC)
					for (int i = frac_no; i < 2; i++) begin
						mag = mag * 10;
						if (mag > 64'sh8000_0000)
							mag = 64'sh8000_0000;
					end
				return clamp_signed(num_neg ? -mag : mag);
			end
			lirfp_pkg::KIND_RFLAG:
				return (lead_char == lirfp_pkg::CHAR_N) ? 32'd0
					: ((lead_char == lirfp_pkg::CHAR_R) ? 32'd1 : 32'd2);
			lirfp_pkg::KIND_SFLAG:
				return (lead_char == lirfp_pkg::CHAR_O) ? 32'd0 : 32'd1;
			lirfp_pkg::KIND_DATE: begin
				// take ascii zero off every position that arrived
				n    = (char_no < 5'd10) ? int'(char_no) : 10;
				bias = 0;
				for (int p = 0; p < n; p++)
					bias = bias + 48 * longint'(DATE_WT[p]);
				return clamp_signed(longint'(acc) - bias);
			end
			lirfp_pkg::KIND_INSTR: begin
				for (int i = 0; i < 4; i++)
					if (instr_hits[i] && int'(char_no) == instr_words[i].len())
						return 32'(i + 1);
				return 32'd0;
			end
			lirfp_pkg::KIND_MODE: begin
				for (int i = 0; i < 3; i++)
					if (mode_hits[i] && int'(char_no) == mode_words[i].len())
						return 32'(i + 1);
				return 32'd0;
			end
			default:
				return 32'd0;
		endcase
	endfunction

	// one byte into the decoder, with the result it causes if any
	task automatic decode_byte(input logic [7:0] b, output bit got, output parse_result_t r);
		lirfp_pkg::kind_t k;
		logic [16:0]      nxt;
		k   = column_kind(col_no);
		got = 1'b0;
		r   = '0;
		if (b == lirfp_pkg::BYTE_PIPE) begin
			if (k != lirfp_pkg::KIND_NONE) begin
				r.column    = col_no;
				r.value     = field_value(k);
				r.kept      = 1'b1;
				r.rec_index = line_no;
				got         = 1'b1;
			end
			if (col_no < lirfp_pkg::COL_MAX)
				col_no = col_no + 5'd1;
			clear_field_state();
		end else if (b == lirfp_pkg::BYTE_NL) begin
			r.column    = col_no;
			r.value     = field_value(k);
			r.kept      = (k != lirfp_pkg::KIND_NONE);
			r.rec_index = line_no;
			r.rec_end   = 1'b1;
			got         = 1'b1;
			nxt         = {1'b0, line_no} + 17'd1;
			if (int'(nxt) >= RECORD_LIMIT)
				nxt = '0;
			line_no = nxt[15:0];
			col_no  = '0;
			clear_field_state();
		end else begin
			if (char_no == 5'd0)
				lead_char = b;
			for (int i = 0; i < 4; i++)
				if (int'(char_no) >= instr_words[i].len() || instr_words[i][char_no] != b)
					instr_hits[i] = 1'b0;
			for (int i = 0; i < 3; i++)
				if (int'(char_no) >= mode_words[i].len() || mode_words[i][char_no] != b)
					mode_hits[i] = 1'b0;
			if (k == lirfp_pkg::KIND_INT)
				number_step(b, 1'b0);
			else if (k == lirfp_pkg::KIND_DEC)
				number_step(b, 1'b1);
			else if (k == lirfp_pkg::KIND_DATE && char_no < 5'd10)
				acc = acc + 32'(b) * DATE_WT[char_no[3:0]];
			if (char_no < lirfp_pkg::POS_MAX)
				char_no = char_no + 5'd1;
		end
	endtask

	// ---------------------------------------------------------------
	// record text generation
	// ---------------------------------------------------------------

	// any byte that is neither a field separator nor a newline
	function automatic logic [7:0] plain_byte();
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == lirfp_pkg::BYTE_NL || v == lirfp_pkg::BYTE_PIPE);
		return v;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			random_text.push_back(s[i]);
	endtask

	task automatic add_plain(input int n);
		repeat (n)
			random_text.push_back(plain_byte());
	endtask

	task automatic add_digits(input int n);
		repeat (n)
			random_text.push_back(lirfp_pkg::BYTE_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// a token suited to the column kind, well formed most of the time
	task automatic add_field(input lirfp_pkg::kind_t k);
		int         sel;
		int         n;
		string      w;
		logic [7:0] date_text [$];
		case (k)
			lirfp_pkg::KIND_INT, lirfp_pkg::KIND_DEC: begin
				repeat ($urandom_range(0, 2))
					if ($urandom_range(0, 2) == 0)
						case ($urandom_range(0, 4))
							0:       random_text.push_back(8'd9);
							1:       random_text.push_back(8'd11);
							2:       random_text.push_back(8'd12);
							3:       random_text.push_back(8'd13);
							default: random_text.push_back(8'd32);
						endcase
				sel = $urandom_range(0, 11);
				if (sel == 0) begin
					if (k == lirfp_pkg::KIND_INT) add_text("2147483647");
					else add_text("21474836.47");
				end else if (sel == 1) begin
					if (k == lirfp_pkg::KIND_INT) add_text("-2147483648");
					else add_text("-21474836.48");
				end else if (sel == 2) begin
					if (k == lirfp_pkg::KIND_INT) add_text("2147483648");
					else add_text("21474836.48");
				end else if (sel == 3) begin
					add_text("-99999999999");
				end else begin
					case ($urandom_range(0, 3))
						0:       random_text.push_back(lirfp_pkg::BYTE_PLUS);
						1:       random_text.push_back(lirfp_pkg::BYTE_MINUS);
						default: ;
					endcase
					add_digits((sel == 4) ? $urandom_range(9, 12) : $urandom_range(0, 5));
					if (k == lirfp_pkg::KIND_DEC && $urandom_range(0, 1) == 1) begin
						random_text.push_back(lirfp_pkg::BYTE_POINT);
						add_digits($urandom_range(0, 4));
					end
				end
				// stray byte that halts the number, sometimes with digits after it
				if ($urandom_range(0, 5) == 0) begin
					add_plain(1);
					add_digits($urandom_range(0, 2));
				end
			end
			lirfp_pkg::KIND_RFLAG, lirfp_pkg::KIND_SFLAG: begin
				case ($urandom_range(0, 5))
					0:       random_text.push_back(lirfp_pkg::CHAR_N);
					1:       random_text.push_back(lirfp_pkg::CHAR_R);
					2:       random_text.push_back(lirfp_pkg::CHAR_O);
					3:       ;
					default: add_plain(1);
				endcase
				if ($urandom_range(0, 3) == 0)
					add_plain($urandom_range(1, 3));
			end
			lirfp_pkg::KIND_DATE: begin
				sel = $urandom_range(0, 7);
				if (sel <= 4) begin
					for (int p = 0; p < 10; p++)
						if (p == 4 || p == 7)
							date_text.push_back(($urandom_range(0, 4) == 0) ? plain_byte()
								: lirfp_pkg::BYTE_MINUS);
						else
							date_text.push_back(lirfp_pkg::BYTE_ZERO + 8'($urandom_range(0, 9)));
					// short dates leave the tail positions at zero
					n = (sel == 4) ? $urandom_range(0, 9) : 10;
					for (int p = 0; p < n; p++)
						random_text.push_back(date_text[p]);
					if ($urandom_range(0, 5) == 0)
						add_plain($urandom_range(1, 3));
				end else if (sel == 5) begin
					// all-high bytes drive the date sum past the signed range
					repeat ($urandom_range(8, 12))
						random_text.push_back(8'hFF);
				end else begin
					add_plain($urandom_range(0, 12));
				end
			end
			lirfp_pkg::KIND_INSTR, lirfp_pkg::KIND_MODE: begin
				if ((k == lirfp_pkg::KIND_INSTR) != ($urandom_range(0, 4) == 0))
					w = instr_words[$urandom_range(0, 3)];
				else
					w = mode_words[$urandom_range(0, 2)];
				case ($urandom_range(0, 5))
					0, 1, 2: add_text(w);
					3:       add_text(w.substr(0, w.len() - 2));
					4: begin
						add_text(w);
						add_plain(1);
					end
					default: add_plain($urandom_range(0, 4));
				endcase
			end
			default:
				add_plain($urandom_range(0, 3));
		endcase
	endtask

	// a whole line: mostly all kept columns, some short, some past column 31
	task automatic add_record();
		int nf;
		case ($urandom_range(0, 9))
			0:       nf = $urandom_range(1, 5);
			1:       nf = $urandom_range(32, 36);
			2, 3:    nf = $urandom_range(12, 17);
			default: nf = 15;
		endcase
		for (int c = 0; c < nf; c++) begin
			add_field(column_kind((c > 31) ? lirfp_pkg::COL_MAX : 5'(c)));
			// raw noise, separators and newlines included, breaks the record shape
			if ($urandom_range(0, 11) == 0)
				repeat ($urandom_range(1, 6))
					random_text.push_back(8'($urandom_range(0, 255)));
			if (c < nf - 1)
				random_text.push_back(lirfp_pkg::BYTE_PIPE);
		end
		random_text.push_back(lirfp_pkg::BYTE_NL);
	endtask

	// ---------------------------------------------------------------
	// input side: offer one byte, hold it until the transfer
	// ---------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input bit typed, input parse_result_t want);
		bit            got;
		parse_result_t r;
		// idle burst before the byte, never between a lowered and raised valid in one step
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 18))
				@(negedge clk);
		end
		in_valid  = 1'b1;
		data_byte = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// transfer done at this edge, so the decoder moves on with it
		decode_byte(b, got, r);
		if (typed)
			pending_fields.push_back(want);
		else if (got)
			pending_fields.push_back(r);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// output side: ready with random stall bursts, none in the calm tail
	// ---------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n || !idle_on) begin
				out_ready  = arst_n;
				stall_left = 0;
			end else if (stall_left > 0) begin
				out_ready  = 1'b0;
				stall_left = stall_left - 1;
			end else if ($urandom_range(0, 5) == 0) begin
				out_ready  = 1'b0;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// every result transfer is held against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_fields.size() == 0) begin
				$error("result with none owed: column %0d value %0d", column, value);
				fail_count++;
			end else begin
				oldest = pending_fields.pop_front();
				if (column !== oldest.column) begin
					$error("column: expected %0d, got %0d", oldest.column, column);
					fail_count++;
				end
				if (value !== oldest.value) begin
					$error("value: expected %0d, got %0d", $signed(oldest.value), value);
					fail_count++;
				end
				if (field_kept !== oldest.kept) begin
					$error("field_kept: expected %0d, got %0d", oldest.kept, field_kept);
					fail_count++;
				end
				if (record_index !== oldest.rec_index) begin
					$error("record_index: expected %0d, got %0d", oldest.rec_index, record_index);
					fail_count++;
				end
				if (record_end !== oldest.rec_end) begin
					$error("record_end: expected %0d, got %0d", oldest.rec_end, record_end);
					fail_count++;
				end
			end
		end
	end

	// hard stop for a hung block
	initial begin
		#(TIME_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int wait_cycles;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = '0;
		col_no    = '0;
		line_no   = '0;
		clear_field_state();
		repeat (2)
			@(negedge clk);
		arst_n = 1'b1;

		// directed table first
		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(directed_table[i].data, directed_table[i].typed, directed_table[i].want);

		// sender holds off until every owed result has come out
		in_valid = 1'b0;
		while (pending_fields.size() != 0)
			@(negedge clk);

		// random records, the last stretch with no idling on either side
		while (random_text.size() < RANDOM_ITEMS)
			add_record();
		for (int i = 0; i < random_text.size(); i++) begin
			idle_on = (i < random_text.size() - CALM_TAIL);
			send_byte(random_text[i], 1'b0, '0);
		end
		in_valid = 1'b0;

		// drain, then wait on for any result that is not owed
		wait_cycles = 0;
		while (pending_fields.size() != 0 && wait_cycles < 5000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (8)
			@(negedge clk);
		if (pending_fields.size() != 0) begin
			$error("%0d results never came out", pending_fields.size());
			fail_count++;
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
hdl/lirfp_pkg.sv
hdl/lirfp_decode.sv
hdl/lineitem_record_field_parser_core.sv
dv/lineitem_record_field_parser_core_tb.sv
